FILE: sv/qfrc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes, reset values and handshake types of the fair-rate controller.
package qfrc_pkg;

  localparam int RateW   = 17;
  localparam int QueueW  = 24;
  localparam int PortW   = 2;
  localparam int ActW    = 2;
  localparam int CfgW    = 24;
  localparam int CfgIdxW = 3;

  // Signed queue differences and the unclamped rate.
  localparam int DiffW = QueueW + 1;
  localparam int NrW   = 25;

  // Gain coefficient is unsigned Q1.16; the quotient part below one is 16 bits.
  localparam int CoefW = 17;
  localparam int QuotW = 16;

  localparam int DEF_PORTS = 4;

  localparam logic [ActW-1:0] ACT_DROP  = 2'd0;
  localparam logic [ActW-1:0] ACT_HALVE = 2'd1;
  localparam logic [ActW-1:0] ACT_PI    = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_RATE_MIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RATE_MAX  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_QUEUE_MAX = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_QUEUE_MID = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_QUEUE_REF = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LINK_RATE = 3'd5;

  localparam logic [RateW-1:0]  RATE_MIN_RST  = 17'd100;
  localparam logic [RateW-1:0]  RATE_MAX_RST  = 17'd10000;
  localparam logic [QueueW-1:0] QUEUE_MAX_RST = 24'd210000;
  localparam logic [QueueW-1:0] QUEUE_MID_RST = 24'd150000;
  localparam logic [QueueW-1:0] QUEUE_REF_RST = 24'd75000;
  localparam logic [RateW-1:0]  LINK_RATE_RST = 17'd10000;

  // Q0.24 gains, rounded to nearest: 0.4/128 and 0.4/32.
  localparam logic [15:0] GAIN_A = 16'd52429;
  localparam logic [17:0] GAIN_B = 18'd209715;

  localparam logic [CoefW-1:0] COEF_ONE = 17'd65536;
  localparam logic [CoefW-1:0] COEF_MIN = 17'd1024;

  typedef struct packed {
    logic                    start;
    logic [DiffW-1:0]        qerr;    // q - queue_ref, two's complement
    logic [DiffW-1:0]        qdelta;  // q - avg, two's complement
    logic [RateW-1:0]        rate;
    logic                    coef_full;
  } pi_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [NrW-1:0]   rate;
  } pi_rsp_t;

endpackage

FILE: sv/queue_fair_rate_controller.sv
`timescale 1ns / 1ps
// Top level of the per-port fair-rate controller.
//
// Each request on the input channel carries a port index and that port's queue
// occupancy in bytes. The block answers every request with exactly one result:
// the new clamped rate in Mbps and the action taken (drop, halve or PI step).
// Both channels use valid and stall; a request moves at an edge with valid high
// and stall low. Port indexes at or above PORTS wrap around.
// A drop or halve goes from the decision step straight to the clamp step; a PI
// step first runs two bit-serial passes, one over the queue differences (the
// link-rate division runs alongside) and one over the gain coefficient. One
// request is in flight at a time: a new request is taken only once the previous
// one has been moved into the output register.
// The result sits in an output register; while the receiver stalls it holds,
// and the block already takes and works on the next request, waiting at the end
// only if the previous result has still not been taken. Configuration is a plain
// write port; the user must write it only while no request is in flight, and the
// block does not enforce this. Reset loads the register defaults, clears every
// stored queue and sets every stored rate to the default maximum rate.
module queue_fair_rate_controller import qfrc_pkg::*; #(
  parameter int PORTS = DEF_PORTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PortW-1:0]   port_index_i,
  input  logic [QueueW-1:0]  queue_bytes_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [RateW-1:0]   new_rate_o,
  output logic [ActW-1:0]    action_o
);

  localparam int PortIdxW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam logic [4:0] PortsC = 5'(PORTS);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_DECIDE  = 2'd1;
  localparam logic [1:0] ST_PI_WAIT = 2'd2;
  localparam logic [1:0] ST_CLAMP   = 2'd3;

  function automatic logic [PortIdxW-1:0] wrap_port(input logic [PortW-1:0] v);
    logic [4:0] t;
    t = 5'(v);
    for (int i = 0; i < 3; i++) begin
      if (t >= PortsC) begin
        t = t - PortsC;
      end
    end
    return t[PortIdxW-1:0];
  endfunction

  logic [RateW-1:0]      rate_min_q, rate_max_q, link_rate_q;
  logic [QueueW-1:0]     queue_max_q, queue_mid_q, queue_ref_q;

  logic [QueueW-1:0]     prev_queue_q [PORTS];
  logic [RateW-1:0]      cur_rate_q [PORTS];

  logic [1:0]            st_q, st_d;
  logic [PortIdxW-1:0]   port_q;
  logic [QueueW-1:0]     queue_q;
  logic signed [NrW-1:0] nr_q;
  logic [ActW-1:0]       act_q;
  logic                  out_valid_q;
  logic [RateW-1:0]      out_rate_q;
  logic [ActW-1:0]       out_act_q;

  logic                  in_accept, out_load;
  logic [QueueW-1:0]     prev_q;
  logic [RateW-1:0]      rate_r;
  logic signed [DiffW-1:0] growth;
  logic [DiffW-1:0]      qp_sum;
  logic [QueueW-1:0]     avg, thr;
  logic                  do_drop, do_halve, low_queue, rate_ge;
  logic signed [NrW-1:0] rmin_ext, rmax_ext, nr_lo, nr_cl;
  pi_req_t               pi_req;
  pi_rsp_t               pi_rsp;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != ST_IDLE);
  assign out_load   = (st_q == ST_CLAMP) && (!out_valid_q || !out_stall_i);

  assign prev_q   = prev_queue_q[port_q];
  assign rate_r   = cur_rate_q[port_q];
  assign growth   = $signed({1'b0, queue_q}) - $signed({1'b0, prev_q});
  assign do_drop  = (queue_q > queue_max_q) && (growth > $signed({1'b0, queue_max_q}));
  assign do_halve = (growth > $signed({1'b0, queue_mid_q}));
  assign qp_sum   = {1'b0, queue_q} + {1'b0, prev_q};
  assign avg      = qp_sum[DiffW-1:1];
  assign thr      = {3'b000, queue_ref_q[QueueW-1:3]};
  assign low_queue = (queue_q < thr) && (avg < thr);
  // Rate at least half the link rate saturates the coefficient at one.
  assign rate_ge  = ({rate_r, 1'b0} >= {1'b0, link_rate_q});

  always_comb begin
    pi_req.start     = (st_q == ST_DECIDE) && !do_drop && !do_halve;
    pi_req.qerr      = {1'b0, queue_q} - {1'b0, queue_ref_q};
    pi_req.qdelta    = {1'b0, queue_q} - {1'b0, avg};
    pi_req.rate      = rate_r;
    pi_req.coef_full = low_queue || rate_ge;
  end

  qfrc_pi_unit u_pi (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (pi_req),
    .link_rate_i (link_rate_q),
    .rsp_o       (pi_rsp)
  );

  // The maximum is applied last, so it wins when the minimum lies above it.
  assign rmin_ext = $signed(NrW'(rate_min_q));
  assign rmax_ext = $signed(NrW'(rate_max_q));
  assign nr_lo    = (nr_q < rmin_ext) ? rmin_ext : nr_q;
  assign nr_cl    = (nr_lo > rmax_ext) ? rmax_ext : nr_lo;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_accept) begin
          st_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        st_d = (do_drop || do_halve) ? ST_CLAMP : ST_PI_WAIT;
      end
      ST_PI_WAIT: begin
        if (pi_rsp.done) begin
          st_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (out_load) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
      rate_min_q  <= RATE_MIN_RST;
      rate_max_q  <= RATE_MAX_RST;
      queue_max_q <= QUEUE_MAX_RST;
      queue_mid_q <= QUEUE_MID_RST;
      queue_ref_q <= QUEUE_REF_RST;
      link_rate_q <= LINK_RATE_RST;
      for (int i = 0; i < PORTS; i++) begin
        prev_queue_q[i] <= '0;
        cur_rate_q[i]   <= RATE_MAX_RST;
      end
    end else begin
      st_q <= st_d;
      if (out_load) begin
        out_valid_q          <= 1'b1;
        prev_queue_q[port_q] <= queue_q;
        cur_rate_q[port_q]   <= nr_cl[RateW-1:0];
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RATE_MIN:  rate_min_q  <= cfg_data_i[RateW-1:0];
          REG_RATE_MAX:  rate_max_q  <= cfg_data_i[RateW-1:0];
          REG_QUEUE_MAX: queue_max_q <= cfg_data_i[QueueW-1:0];
          REG_QUEUE_MID: queue_mid_q <= cfg_data_i[QueueW-1:0];
          REG_QUEUE_REF: queue_ref_q <= cfg_data_i[QueueW-1:0];
          REG_LINK_RATE: link_rate_q <= cfg_data_i[RateW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      port_q  <= wrap_port(port_index_i);
      queue_q <= queue_bytes_i;
    end
    if (st_q == ST_DECIDE) begin
      if (do_drop) begin
        nr_q  <= rmin_ext;
        act_q <= ACT_DROP;
      end else if (do_halve) begin
        nr_q  <= $signed(NrW'(rate_r[RateW-1:1]));
        act_q <= ACT_HALVE;
      end else begin
        act_q <= ACT_PI;
      end
    end
    if ((st_q == ST_PI_WAIT) && pi_rsp.done) begin
      nr_q <= pi_rsp.rate;
    end
    if (out_load) begin
      out_rate_q <= nr_cl[RateW-1:0];
      out_act_q  <= act_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_rate_o  = out_rate_q;
  assign action_o    = out_act_q;

  a_pi_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pi_rsp.done |-> (st_q == ST_PI_WAIT))
    else $error("PI unit finished while no request waited for it");

  a_accept_starts_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (st_q == ST_DECIDE))
    else $error("accepted request did not enter the decision step");

  a_action_code_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (action_o == ACT_DROP || action_o == ACT_HALVE || action_o == ACT_PI))
    else $error("result carries an undefined action code");

  a_result_within_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (nr_cl <= rmax_ext))
    else $error("clamped rate exceeds the maximum rate");

endmodule

FILE: sv/qfrc_pi_unit.sv
`timescale 1ns / 1ps
// Bit-serial PI step: gain products, coefficient division and the scaled correction.
module qfrc_pi_unit import qfrc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pi_req_t          req_i,
  input  logic [RateW-1:0] link_rate_i,
  output pi_rsp_t          rsp_o
);

  localparam int AccW     = 21;
  localparam int SumW     = AccW + DiffW;
  localparam int GainSumW = 19;
  localparam int FracW    = 40;
  localparam int CorrShift = FracW - CoefW;
  localparam int CorrW    = SumW - CorrShift;
  localparam int CntW     = $clog2(DiffW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]            st_q, st_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  done_q, done_d;

  logic [DiffW-1:0]      x_q, y_q;
  logic [AccW-1:0]       acc_q;
  logic [DiffW-1:0]      lo_q;
  logic [RateW-1:0]      rem_q;
  logic [QuotW-1:0]      quot_q;
  logic                  full_q;
  logic [RateW-1:0]      r_q;
  logic [SumW-1:0]       mag_q;
  logic                  neg_q;
  logic [CoefW-1:0]      coef_q;
  logic [SumW-1:0]       hi_q;
  logic signed [NrW-1:0] rate_q;

  logic [GainSumW-1:0]   addend;
  logic [AccW:0]         acc_ext, add_ext, sum1;
  logic                  last1, last2;
  logic [RateW:0]        rem2, link_ext;
  logic                  rem_ge;
  logic [SumW-1:0]       s_val;
  logic [SumW:0]         sum2;
  logic [CorrW-1:0]      corr;
  logic [CoefW-1:0]      quot_ext;

  // One bit of each difference per cycle; the last bit carries negative weight.
  assign addend  = (x_q[0] ? GainSumW'(GAIN_A) : '0) + (y_q[0] ? GainSumW'(GAIN_B) : '0);
  assign acc_ext = {acc_q[AccW-1], acc_q};
  assign add_ext = (AccW + 1)'(addend);
  assign last1   = (cnt_q == CntW'(DiffW - 1));
  assign sum1    = last1 ? (acc_ext - add_ext) : (acc_ext + add_ext);

  // Restoring division of rate * 2^17 by the link rate, one quotient bit per cycle.
  assign rem2     = {rem_q, 1'b0};
  assign link_ext = {1'b0, link_rate_i};
  assign rem_ge   = (rem2 >= link_ext);

  assign s_val    = {acc_q, lo_q};
  assign quot_ext = {1'b0, quot_q};
  assign sum2     = {1'b0, hi_q} + {1'b0, (coef_q[0] ? mag_q : '0)};
  assign last2    = (cnt_q == CntW'(CoefW - 1));
  assign corr     = hi_q[SumW-1:CorrShift];

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (req_i.start) begin
          st_d  = S_MUL1;
          cnt_d = '0;
        end
      end
      S_MUL1: begin
        cnt_d = cnt_q + 1'b1;
        if (last1) begin
          st_d = S_LOAD;
        end
      end
      S_LOAD: begin
        st_d  = S_MUL2;
        cnt_d = '0;
      end
      S_MUL2: begin
        cnt_d = cnt_q + 1'b1;
        if (last2) begin
          st_d = S_FIN;
        end
      end
      S_FIN: begin
        st_d   = S_IDLE;
        done_d = 1'b1;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (req_i.start) begin
          x_q    <= req_i.qerr;
          y_q    <= req_i.qdelta;
          acc_q  <= '0;
          r_q    <= req_i.rate;
          full_q <= req_i.coef_full;
          // When the coefficient is not saturated, 2 * rate is below the link rate.
          rem_q  <= req_i.coef_full ? '0 : {req_i.rate[RateW-2:0], 1'b0};
        end
      end
      S_MUL1: begin
        x_q   <= {1'b0, x_q[DiffW-1:1]};
        y_q   <= {1'b0, y_q[DiffW-1:1]};
        acc_q <= sum1[AccW:1];
        lo_q  <= {sum1[0], lo_q[DiffW-1:1]};
        if (cnt_q < CntW'(QuotW)) begin
          rem_q  <= rem_ge ? RateW'(rem2 - link_ext) : rem2[RateW-1:0];
          quot_q <= {quot_q[QuotW-2:0], rem_ge};
        end
      end
      S_LOAD: begin
        neg_q  <= s_val[SumW-1];
        mag_q  <= s_val[SumW-1] ? (~s_val + 1'b1) : s_val;
        hi_q   <= '0;
        if (full_q) begin
          coef_q <= COEF_ONE;
        end else if (quot_ext < COEF_MIN) begin
          coef_q <= COEF_MIN;
        end else begin
          coef_q <= quot_ext;
        end
      end
      S_MUL2: begin
        hi_q   <= sum2[SumW:1];
        coef_q <= {1'b0, coef_q[CoefW-1:1]};
      end
      S_FIN: begin
        // The correction is truncated toward zero, so its sign is applied last.
        if (neg_q) begin
          rate_q <= $signed(NrW'(r_q)) + $signed(NrW'(corr));
        end else begin
          rate_q <= $signed(NrW'(r_q)) - $signed(NrW'(corr));
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rate = rate_q;

endmodule
